@@ sv/chained_hash_set_top_macros.svh @@
// Assertion macros for the hash set modules.
// Depends on nothing; included by modules that check their own logic.
`ifndef CHAINED_HASH_SET_TOP_MACROS_SVH
`define CHAINED_HASH_SET_TOP_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CHS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Implication whose consequence is checked in the cycle after the antecedent.
`define CHS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

@@ sv/chs_pkg.sv @@
// Types and constants shared by the hash set controller, datapath and top level.
// Depends on nothing.
`timescale 1ns / 1ps
package chs_pkg;
	localparam int CFG_BITS = 11;
	localparam int IDX_BITS = 12;
	localparam int KEY_IN_BITS = 32;

	localparam logic OP_FIND = 1'b0;
	localparam logic OP_INSERT = 1'b1;

	typedef struct packed {
		logic opcode;
		logic [KEY_IN_BITS-1:0] key;
	} req_t;

	typedef struct packed {
		logic hit;
		logic [IDX_BITS-1:0] node_index;
		logic added;
		logic pool_full;
	} rsp_t;

	// Controller to datapath.
	typedef struct packed {
		logic load;        // capture request, start the modulo
		logic mod_step;    // one restoring-division step
		logic head_rd;     // read bucket head
		logic head_take;   // pointer <= head read data
		logic node_rd;     // read node at pointer
		logic node_take;   // compare and advance pointer
		logic write_node;  // link new node at head
		logic emit;        // load output register
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic mod_done;
		logic ptr_nil;
		logic match;
		logic is_insert;
		logic pool_avail;
	} sts_t;
endpackage

@@ sv/chained_hash_set_top.sv @@
// Top level of the hash set: joins controller and datapath.
// Depends on chs_pkg, chs_ctrl and chs_datapath.
`timescale 1ns / 1ps
// Channel   Direction  Handshake           Payload
// req       in         req_valid/req_stall chs_pkg::req_t (opcode, key)
// rsp       out        rsp_valid/rsp_stall chs_pkg::rsp_t (hit, node_index, added, pool_full)
// cfg       in         cfg_we              cfg_data (bucket_count)
// An item is accepted, then runs the bit-serial modulo, the head read (S_HEAD, S_TAKE), a
// read and compare per chain node (S_CHECK, S_CMP) and, on a miss, the emit.
// A hit emits in the compare state of the matching node.
// After reset every bucket of the head memory is cleared; req is stalled.
// A held result only blocks the final emit step; the next item waits for it.
module chained_hash_set_top #(
	parameter int MAX_BUCKETS = 1024,
	parameter int POOL_NODES = 4096,
	parameter int KEY_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [chs_pkg::CFG_BITS-1:0] cfg_data,
	input  logic req_valid,
	output logic req_stall,
	input  chs_pkg::req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output chs_pkg::rsp_t rsp
);
	chs_pkg::cmd_t cmd;
	chs_pkg::sts_t sts;
	logic clear_en;
	logic [$clog2(MAX_BUCKETS)-1:0] clear_addr;

	chs_ctrl #(.MAX_BUCKETS(MAX_BUCKETS)) u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(req_valid), .in_stall(req_stall),
		.out_valid(rsp_valid), .out_stall(rsp_stall),
		.sts(sts), .cmd(cmd), .clear_en(clear_en), .clear_addr(clear_addr)
	);

	chs_datapath #(
		.MAX_BUCKETS(MAX_BUCKETS), .POOL_NODES(POOL_NODES), .KEY_BITS(KEY_BITS)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.req(req), .cmd(cmd), .sts(sts), .rsp_q(rsp),
		.clear_en(clear_en), .clear_addr(clear_addr)
	);
endmodule

@@ sv/chs_datapath.sv @@
// Datapath of the hash set: modulo unit, head memory, node memories, output register.
// Depends on chs_pkg.
`timescale 1ns / 1ps
module chs_datapath #(
	parameter int MAX_BUCKETS = 1024,
	parameter int POOL_NODES = 4096,
	parameter int KEY_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [chs_pkg::CFG_BITS-1:0] cfg_data,
	input  chs_pkg::req_t req,
	input  chs_pkg::cmd_t cmd,
	output chs_pkg::sts_t sts,
	output chs_pkg::rsp_t rsp_q,
	input  logic clear_en,
	input  logic [$clog2(MAX_BUCKETS)-1:0] clear_addr
);
	localparam int BA = $clog2(MAX_BUCKETS);
	localparam int NA = $clog2(POOL_NODES);
	localparam int PW = NA + 1;
	localparam int BW = $clog2(MAX_BUCKETS + 1);
	localparam int KW = KEY_BITS;
	localparam int MW = (KW > BW) ? KW : BW;
	localparam logic [PW-1:0] NIL = PW'(POOL_NODES);
	localparam int CNT_W = $clog2(KW + 1);

	logic [chs_pkg::CFG_BITS-1:0] bucket_count_q;
	logic [BW-1:0] div_q;
	logic [KW-1:0] key_q;
	logic op_q;
	logic [KW-1:0] quo_q;
	logic [BW:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic [PW-1:0] ptr_q;
	logic [PW-1:0] used_q;
	logic [BA-1:0] bucket;
	logic [PW-1:0] head_rd_s1;
	logic [KW-1:0] nkey_rd_s1;
	logic [PW-1:0] nlink_rd_s1;
	logic [BW:0] rem_sh;
	logic [KW-1:0] key_in;
	logic [MW-1:0] cfg_ext;

	logic [PW-1:0] heads_mem [MAX_BUCKETS];
	logic [KW-1:0] keys_mem [POOL_NODES];
	logic [PW-1:0] links_mem [POOL_NODES];

	always_comb begin
		key_in = KW'(req.key);
		cfg_ext = MW'(bucket_count_q);
		rem_sh = {rem_q[BW-1:0], quo_q[KW-1]};
		bucket = BA'(rem_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_count_q <= chs_pkg::CFG_BITS'(11);
		end else if (cfg_we) begin
			bucket_count_q <= cfg_data;
		end
	end

	// Restoring division, one quotient bit a cycle; only the remainder is kept.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.load) begin
			cnt_q <= CNT_W'(KW);
		end else if (cmd.mod_step && cnt_q != '0) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q <= key_in;
			quo_q <= key_in;
			op_q <= req.opcode;
			rem_q <= '0;
			if (bucket_count_q == '0)
				div_q <= BW'(1);
			else if (cfg_ext > MW'(MAX_BUCKETS))
				div_q <= BW'(MAX_BUCKETS);
			else
				div_q <= BW'(bucket_count_q);
		end else if (cmd.mod_step && cnt_q != '0) begin
			quo_q <= quo_q << 1;
			if (rem_sh >= {1'b0, div_q})
				rem_q <= rem_sh - {1'b0, div_q};
			else
				rem_q <= rem_sh;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (cmd.write_node) begin
			used_q <= used_q + PW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (clear_en)
			heads_mem[clear_addr] <= NIL;
		else if (cmd.write_node)
			heads_mem[bucket] <= used_q;
		if (cmd.head_rd)
			head_rd_s1 <= heads_mem[bucket];
	end

	always_ff @(posedge clk) begin
		if (cmd.write_node) begin
			keys_mem[NA'(used_q)] <= key_q;
			links_mem[NA'(used_q)] <= head_rd_s1;
		end
		if (cmd.node_rd) begin
			nkey_rd_s1 <= keys_mem[NA'(ptr_q)];
			nlink_rd_s1 <= links_mem[NA'(ptr_q)];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.head_take)
			ptr_q <= head_rd_s1;
		else if (cmd.node_take && nkey_rd_s1 != key_q)
			ptr_q <= nlink_rd_s1;
	end

	always_comb begin
		sts.mod_done = (cnt_q == '0);
		sts.ptr_nil = (ptr_q >= NIL);
		sts.match = (nkey_rd_s1 == key_q);
		sts.is_insert = (op_q == chs_pkg::OP_INSERT);
		sts.pool_avail = (used_q < NIL);
	end

	// The controller raises emit with write_node for an add, with node_take on a
	// match, and alone for a miss or a full pool.
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			rsp_q.hit <= cmd.node_take;
			rsp_q.node_index <= cmd.node_take ? chs_pkg::IDX_BITS'(ptr_q)
				: (cmd.write_node ? chs_pkg::IDX_BITS'(used_q) : '0);
			rsp_q.added <= cmd.write_node;
			rsp_q.pool_full <= !cmd.node_take && !cmd.write_node &&
				(op_q == chs_pkg::OP_INSERT);
		end
	end
endmodule

@@ sv/chs_ctrl.sv @@
// Controller of the hash set: sequences head clear, modulo, chain walk, insert and handshakes.
// Depends on chs_pkg and chained_hash_set_top_macros.svh.
`timescale 1ns / 1ps
`include "chained_hash_set_top_macros.svh"
module chs_ctrl #(
	parameter int MAX_BUCKETS = 1024
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input  logic out_stall,
	input  chs_pkg::sts_t sts,
	output chs_pkg::cmd_t cmd,
	output logic clear_en,
	output logic [$clog2(MAX_BUCKETS)-1:0] clear_addr
);
	localparam int BA = $clog2(MAX_BUCKETS);
	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_MOD = 3'd2;
	localparam logic [2:0] S_HEAD = 3'd3;
	localparam logic [2:0] S_TAKE = 3'd4;
	localparam logic [2:0] S_CHECK = 3'd5;
	localparam logic [2:0] S_CMP = 3'd6;

	logic [2:0] state_q, state_d;
	logic [BA:0] clr_q;
	logic out_valid_q;
	logic out_free;
	logic accept;

	assign out_valid = out_valid_q;
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != S_IDLE);
	assign accept = in_valid && !in_stall;
	assign clear_en = (state_q == S_CLEAR);
	assign clear_addr = clr_q[BA-1:0];

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			S_CLEAR: begin
				if (clr_q == (BA+1)'(MAX_BUCKETS - 1))
					state_d = S_IDLE;
			end
			S_IDLE: begin
				if (accept) begin
					cmd.load = 1'b1;
					state_d = S_MOD;
				end
			end
			S_MOD: begin
				cmd.mod_step = 1'b1;
				if (sts.mod_done)
					state_d = S_HEAD;
			end
			S_HEAD: begin
				cmd.head_rd = 1'b1;
				state_d = S_TAKE;
			end
			S_TAKE: begin
				cmd.head_take = 1'b1;
				state_d = S_CHECK;
			end
			S_CHECK: begin
				if (!sts.ptr_nil) begin
					cmd.node_rd = 1'b1;
					state_d = S_CMP;
				end else if (out_free) begin
					cmd.emit = 1'b1;
					cmd.write_node = sts.is_insert && sts.pool_avail;
					state_d = S_IDLE;
				end
			end
			S_CMP: begin
				if (!sts.match) begin
					cmd.node_take = 1'b1;
					state_d = S_CHECK;
				end else if (out_free) begin
					cmd.node_take = 1'b1;
					cmd.emit = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR)
				clr_q <= clr_q + (BA+1)'(1);
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	`CHS_ASSERT_IMP(a_emit_room, clk, arst_n, cmd.emit, out_free, "emit while output held")
	`CHS_ASSERT_IMP(a_write_miss, clk, arst_n, cmd.write_node,
		sts.ptr_nil && sts.pool_avail, "node written on hit or full pool")
	`CHS_ASSERT_NEXT(a_accept_mod, clk, arst_n, accept, state_q == S_MOD,
		"accepted item did not start modulo")
	`CHS_ASSERT_IMP(a_no_accept_clear, clk, arst_n, state_q == S_CLEAR, in_stall,
		"input not stalled during head clear")
endmodule
